@@ rtl/variable_record_ring_buffer_top_macros.svh @@
// Assertion helpers for the record ring buffer.
// Each check is clocked by clk_i and held off while rst_ni is low.
`ifndef VARIABLE_RECORD_RING_BUFFER_TOP_MACROS_SVH
`define VARIABLE_RECORD_RING_BUFFER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define VRRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vrrb check failed");

`define VRRB_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("vrrb sequence check failed");

`else

`define VRRB_ASSERT(lbl, prop)

`define VRRB_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ rtl/vrrb_pkg.sv @@
package vrrb_pkg;

  // Default geometry
  localparam int unsigned RingBytesDef = 4096;
  localparam int unsigned LineLimitDef = 256;

  // Widest ring position the request bus carries
  localparam int unsigned PosMaxW = 16;

  // Record layout
  localparam int unsigned HdrBytes  = 6;
  localparam int unsigned OverBytes = 8;

  localparam logic [7:0] NewlineChar = 8'd10;

  // Item kinds
  localparam logic [1:0] KindAppend   = 2'd0;
  localparam logic [1:0] KindSetAttr  = 2'd1;
  localparam logic [1:0] KindTruncate = 2'd2;
  localparam logic [1:0] KindRead     = 2'd3;

  // Memory port request from the controller
  typedef struct packed {
    logic               we;
    logic [PosMaxW-1:0] waddr;
    logic [7:0]         wdata;
    logic [PosMaxW-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/variable_record_ring_buffer_top.sv @@
// Line log ring buffer. Records are stored in a RingBytes-byte ring as
// length (2 bytes, little-endian), attribute (4 bytes), body, length copy.
// Each item yields one result. After reset a pass writes the initial empty
// record; items are taken once it ends. All work goes through one byte
// memory with one write port and one read port. An item is taken only in
// the idle state, so the next item waits until the last one has finished.
// A character is dropped at the line limit or for lack of room. Each
// evicted record adds the steps S_EV_CHK, S_EV_R1 and S_EV_R2 to an append
// or a newline, with two memory reads of its length. A finished result
// sits in an output register, so the next item is taken while it waits; a
// stalled output register holds the following result in S_DONE.
module variable_record_ring_buffer_top #(
  parameter int unsigned RingBytes = vrrb_pkg::RingBytesDef,
  parameter int unsigned LineLimit = vrrb_pkg::LineLimitDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [31:0]                        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         kind_i,
  input  logic [7:0]                         char_value_i,
  input  logic [31:0]                        attribute_i,
  input  logic [7:0]                         new_length_i,
  input  logic [11:0]                        read_address_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         read_byte_o,
  output logic [$clog2(RingBytes + 1)-1:0]   bytes_used_o,
  output logic [$clog2(RingBytes)-1:0]       write_position_o,
  output logic [7:0]                         line_length_o,
  output logic                               char_dropped_o
);
  import vrrb_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  vrrb_ctrl #(
    .RingBytes(RingBytes),
    .LineLimit(LineLimit)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .char_value_i    (char_value_i),
    .attribute_i     (attribute_i),
    .new_length_i    (new_length_i),
    .read_address_i  (read_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_byte_o     (read_byte_o),
    .bytes_used_o    (bytes_used_o),
    .write_position_o(write_position_o),
    .line_length_o   (line_length_o),
    .char_dropped_o  (char_dropped_o),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  vrrb_ram #(
    .Depth(RingBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

endmodule

@@ rtl/vrrb_ram.sv @@
module vrrb_ram #(
  parameter int unsigned Depth = vrrb_pkg::RingBytesDef
) (
  input  logic               clk_i,
  input  vrrb_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);
  import vrrb_pkg::*;

  localparam int unsigned AW = $clog2(Depth);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr[AW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vrrb_ctrl.sv @@
`include "variable_record_ring_buffer_top_macros.svh"

module vrrb_ctrl #(
  parameter int unsigned RingBytes = vrrb_pkg::RingBytesDef,
  parameter int unsigned LineLimit = vrrb_pkg::LineLimitDef,
  localparam int unsigned PW = $clog2(RingBytes),
  localparam int unsigned CW = $clog2(RingBytes + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         char_value_i,
  input  logic [31:0]        attribute_i,
  input  logic [7:0]         new_length_i,
  input  logic [11:0]        read_address_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_byte_o,
  output logic [CW-1:0]      bytes_used_o,
  output logic [PW-1:0]      write_position_o,
  output logic [7:0]         line_length_o,
  output logic               char_dropped_o,
  output vrrb_pkg::mem_req_t mem_req_o,
  input  logic [7:0]         mem_rdata_i
);
  import vrrb_pkg::*;

  localparam int unsigned LW = (LineLimit > 2) ? $clog2(LineLimit) : 1;

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_EV_CHK = 10'b00_0000_0100,
    S_EV_R1  = 10'b00_0000_1000,
    S_EV_R2  = 10'b00_0001_0000,
    S_POST   = 10'b00_0010_0000,
    S_WR     = 10'b00_0100_0000,
    S_RD     = 10'b00_1000_0000,
    S_RDCAP  = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] p, logic [PW:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + k;
    if (s >= (PW+1)'(RingBytes)) s = s - (PW+1)'(RingBytes);
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] wrap_sub(logic [PW-1:0] p, logic [PW:0] k);
    logic [PW:0] s;
    if ({1'b0, p} >= k) s = {1'b0, p} - k;
    else                s = {1'b0, p} + (PW+1)'(RingBytes) - k;
    return s[PW-1:0];
  endfunction

  state_e        state_q, state_d;
  logic [2:0]    init_q, init_d;
  logic [31:0]   dattr_q;
  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] used_q, used_d;
  logic [PW-1:0] open_q, open_d;
  logic [LW-1:0] len_q, len_d;

  // Latched item
  logic [7:0]    ch_q, ch_d;
  logic [11:0]   addr_q, addr_d;
  logic          nl_q, nl_d;
  logic          drop_q, drop_d;
  logic [7:0]    rbyte_q, rbyte_d;

  // Eviction walk
  logic [PW-1:0] tail_q, tail_d;
  logic [7:0]    lo_q, lo_d;

  // Write sequencer: segment A in flight, segment B pending
  logic [PW-1:0] wa_q, wa_d;
  logic [63:0]   wdat_q, wdat_d;
  logic [3:0]    wcnt_q, wcnt_d;
  logic [PW-1:0] wb_q, wb_d;
  logic [15:0]   wbdat_q, wbdat_d;
  logic [1:0]    wbcnt_q, wbcnt_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic [7:0]    o_rbyte_q, o_rbyte_d;
  logic [CW-1:0] o_used_q, o_used_d;
  logic [PW-1:0] o_head_q, o_head_d;
  logic [7:0]    o_len_q, o_len_d;
  logic          o_drop_q, o_drop_d;

  logic [PW-1:0] tail;
  logic          ev_more;
  logic [16:0]   rec;
  logic [15:0]   len16;
  logic [LW-1:0] delta;
  logic          slot_free;

  assign tail    = wrap_sub(head_q, (PW+1)'(used_q));
  assign ev_more = ((32'(used_q) + (nl_q ? 32'(OverBytes) : 32'd1)) > 32'(RingBytes))
                   && (used_q != '0) && !(!nl_q && (tail == open_q));
  assign rec     = 17'(OverBytes) + {1'b0, mem_rdata_i, lo_q};
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    head_d  = head_q;
    used_d  = used_q;
    open_d  = open_q;
    len_d   = len_q;
    ch_d    = ch_q;
    addr_d  = addr_q;
    nl_d    = nl_q;
    drop_d  = drop_q;
    rbyte_d = rbyte_q;
    tail_d  = tail_q;
    lo_d    = lo_q;
    wa_d    = wa_q;
    wdat_d  = wdat_q;
    wcnt_d  = wcnt_q;
    wb_d    = wb_q;
    wbdat_d = wbdat_q;
    wbcnt_d = wbcnt_q;
    len16   = '0;
    delta   = '0;

    out_valid_d = out_valid_q && out_stall_i;
    o_rbyte_d   = o_rbyte_q;
    o_used_d    = o_used_q;
    o_head_d    = o_head_q;
    o_len_d     = o_len_q;
    o_drop_d    = o_drop_q;

    mem_req_o       = '0;
    mem_req_o.raddr = PosMaxW'(tail);

    unique case (state_q)
      // Write the initial empty record
      S_INIT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = PosMaxW'(init_q);
        init_d          = init_q + 3'd1;
        if (init_q == 3'd7) state_d = S_IDLE;
      end

      // Take an item and dispatch on its kind
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d    = char_value_i;
          addr_d  = read_address_i;
          drop_d  = 1'b0;
          rbyte_d = '0;
          wbcnt_d = '0;
          unique case (kind_i)
            KindAppend: begin
              if (char_value_i == NewlineChar) begin
                nl_d    = 1'b1;
                state_d = S_EV_CHK;
              end else if (32'(len_q) + 32'd1 >= 32'(LineLimit)) begin
                drop_d  = 1'b1;
                state_d = S_DONE;
              end else begin
                nl_d    = 1'b0;
                state_d = S_EV_CHK;
              end
            end
            KindSetAttr: begin
              wa_d    = wrap_add(open_q, (PW+1)'(2));
              wdat_d  = {32'b0, attribute_i};
              wcnt_d  = 4'd4;
              state_d = S_WR;
            end
            KindTruncate: begin
              if (32'(new_length_i) < 32'(len_q)) begin
                delta   = len_q - LW'(new_length_i);
                head_d  = wrap_sub(head_q, (PW+1)'(delta));
                used_d  = (32'(delta) <= 32'(used_q)) ? used_q - CW'(delta) : '0;
                len_d   = LW'(new_length_i);
                wa_d    = open_q;
                wdat_d  = {48'b0, 8'b0, new_length_i};
                wcnt_d  = 4'd2;
                wb_d    = wrap_add(open_q, (PW+1)'(HdrBytes) + (PW+1)'(new_length_i));
                wbdat_d = {8'b0, new_length_i};
                wbcnt_d = 2'd2;
                state_d = S_WR;
              end else begin
                state_d = S_DONE;
              end
            end
            KindRead: state_d = S_RD;
            default: state_d = S_DONE;
          endcase
        end
      end

      // Evict the oldest record while room is short
      S_EV_CHK: begin
        if (ev_more) begin
          tail_d  = tail;
          state_d = S_EV_R1;
        end else begin
          state_d = S_POST;
        end
      end

      S_EV_R1: begin
        lo_d            = mem_rdata_i;
        mem_req_o.raddr = PosMaxW'(wrap_add(tail_q, (PW+1)'(1)));
        state_d         = S_EV_R2;
      end

      S_EV_R2: begin
        used_d  = (32'(rec) <= 32'(used_q)) ? CW'(32'(used_q) - 32'(rec)) : '0;
        state_d = S_EV_CHK;
      end

      // Open a new record, or place or drop the character
      S_POST: begin
        if (nl_q) begin
          open_d  = head_q;
          head_d  = wrap_add(head_q, (PW+1)'(OverBytes));
          used_d  = used_q + CW'(OverBytes);
          len_d   = '0;
          wa_d    = head_q;
          wdat_d  = {16'b0, dattr_q, 16'b0};
          wcnt_d  = 4'd8;
          state_d = S_WR;
        end else if (32'(used_q) + 32'd1 > 32'(RingBytes)) begin
          drop_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          len16   = 16'(len_q) + 16'd1;
          head_d  = wrap_add(head_q, (PW+1)'(1));
          used_d  = used_q + CW'(1);
          len_d   = len_q + LW'(1);
          wa_d    = wrap_add(open_q, (PW+1)'(HdrBytes) + (PW+1)'(len_q));
          wdat_d  = {40'b0, len16, ch_q};
          wcnt_d  = 4'd3;
          wb_d    = open_q;
          wbdat_d = len16;
          wbcnt_d = 2'd2;
          state_d = S_WR;
        end
      end

      // Write one byte a cycle, then the pending segment
      S_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = PosMaxW'(wa_q);
        mem_req_o.wdata = wdat_q[7:0];
        wa_d            = wrap_add(wa_q, (PW+1)'(1));
        wdat_d          = {8'b0, wdat_q[63:8]};
        wcnt_d          = wcnt_q - 4'd1;
        if (wcnt_q == 4'd1) begin
          if (wbcnt_q != '0) begin
            wa_d    = wb_q;
            wdat_d  = {48'b0, wbdat_q};
            wcnt_d  = 4'(wbcnt_q);
            wbcnt_d = '0;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_RD: begin
        mem_req_o.raddr = PosMaxW'(addr_q);
        state_d         = S_RDCAP;
      end

      S_RDCAP: begin
        rbyte_d = (32'(addr_q) < 32'(RingBytes)) ? mem_rdata_i : '0;
        state_d = S_DONE;
      end

      // Hand the result to the output register
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          o_rbyte_d   = rbyte_q;
          o_used_d    = used_q;
          o_head_d    = head_q;
          o_len_d     = 8'(len_q);
          o_drop_d    = drop_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      dattr_q     <= '0;
      head_q      <= PW'(OverBytes);
      used_q      <= CW'(OverBytes);
      open_q      <= '0;
      len_q       <= '0;
      wbcnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      head_q      <= head_d;
      used_q      <= used_d;
      open_q      <= open_d;
      len_q       <= len_d;
      wbcnt_q     <= wbcnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) dattr_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    addr_q    <= addr_d;
    nl_q      <= nl_d;
    drop_q    <= drop_d;
    rbyte_q   <= rbyte_d;
    tail_q    <= tail_d;
    lo_q      <= lo_d;
    wa_q      <= wa_d;
    wdat_q    <= wdat_d;
    wcnt_q    <= wcnt_d;
    wb_q      <= wb_d;
    wbdat_q   <= wbdat_d;
    o_rbyte_q <= o_rbyte_d;
    o_used_q  <= o_used_d;
    o_head_q  <= o_head_d;
    o_len_q   <= o_len_d;
    o_drop_q  <= o_drop_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign read_byte_o      = o_rbyte_q;
  assign bytes_used_o     = o_used_q;
  assign write_position_o = o_head_q;
  assign line_length_o    = o_len_q;
  assign char_dropped_o   = o_drop_q;

  `VRRB_ASSERT(a_used_bound, 32'(used_q) <= 32'(RingBytes))
  `VRRB_ASSERT(a_head_bound, 32'(head_q) < 32'(RingBytes))
  `VRRB_ASSERT(a_len_bound, 32'(len_q) < 32'(LineLimit))
  `VRRB_ASSERT_NEXT(a_done_loads, (state_q == S_DONE) && slot_free, out_valid_q)

endmodule
